[hdl/fto_pkg.sv]
`default_nettype none
package fto_pkg;

   localparam int CAP     = 1024;
   localparam int IDX_CAP = 2 * CAP;
   localparam int SLOTW   = $clog2(CAP);
   localparam int IDXW    = $clog2(IDX_CAP);
   localparam int CNTW    = $clog2(CAP + 1);
   localparam int KEYW    = 145;
   localparam int HASH_CHUNKS = (KEYW + IDXW - 1) / IDXW;

   localparam logic [2:0] ACT_LOOKUP = 3'd0;
   localparam logic [2:0] ACT_PUT    = 3'd1;
   localparam logic [2:0] ACT_REMOVE = 3'd2;
   localparam logic [2:0] ACT_EVICT  = 3'd3;
   localparam logic [2:0] ACT_EXPIRE = 3'd4;
   localparam logic [2:0] ACT_READ   = 3'd5;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   localparam logic [7:0] CSR_IDLE_TIMEOUT = 8'd0;
   localparam logic [7:0] CSR_EXPIRE_BUDGET = 8'd1;

   typedef struct packed {
      logic [16:0] pf;
      logic [63:0] hi;
      logic [63:0] lo;
   } key_type;

   typedef struct packed {
      logic        used;
      logic [15:0] handle;
      key_type     key;
      logic [16:0] backend_pf;
      logic [63:0] backend_hi;
      logic [63:0] backend_lo;
      logic [31:0] last_seen;
   } entry_type;

   typedef struct packed {
      logic [2:0]  action;
      logic        client_is_v6;
      logic [63:0] client_addr_hi;
      logic [63:0] client_addr_lo;
      logic [15:0] client_port;
      logic        backend_is_v6;
      logic [63:0] backend_addr_hi;
      logic [63:0] backend_addr_lo;
      logic [15:0] backend_port;
      logic [15:0] handle;
      logic [31:0] now;
      logic [9:0]  slot;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [9:0]  result_slot;
      logic [15:0] result_handle;
      logic        result_backend_is_v6;
      logic [63:0] result_backend_hi;
      logic [63:0] result_backend_lo;
      logic [15:0] result_backend_port;
      logic [31:0] result_last_seen;
      logic [5:0]  removed_count;
      logic        last;
   } res_type;

   typedef struct packed {
      logic [31:0] idle_timeout;
      logic [5:0]  expire_budget;
   } cfg_type;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic [SLOTW-1:0] push_slot;
   } stk_cmd_type;

   typedef struct packed {
      logic             busy;
      logic [CNTW-1:0]  count;
      logic [SLOTW-1:0] pop_slot;
   } stk_stat_type;

   function automatic logic [IDXW-1:0] key_hash(key_type k);
      logic [HASH_CHUNKS*IDXW-1:0] v;
      logic [IDXW-1:0] h;
      v = {{(HASH_CHUNKS*IDXW-KEYW){1'b0}}, k};
      h = '0;
      for (int i = 0; i < HASH_CHUNKS; i++) begin
         h = h ^ v[i*IDXW +: IDXW];
      end
      return h;
   endfunction

   function automatic key_type req_key(req_type r);
      key_type k;
      k.pf = {r.client_is_v6, r.client_port};
      k.hi = r.client_addr_hi;
      k.lo = r.client_addr_lo;
      return k;
   endfunction

   function automatic res_type res_plain(logic [1:0] status, logic [9:0] slot,
                                         logic [5:0] removed);
      res_type r;
      r = '0;
      r.kind = KIND_ANSWER;
      r.status = status;
      r.result_slot = slot;
      r.removed_count = removed;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic res_type res_notice(logic [9:0] slot, logic [15:0] handle);
      res_type r;
      r = '0;
      r.kind = KIND_NOTICE;
      r.status = STATUS_OK;
      r.result_slot = slot;
      r.result_handle = handle;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic res_type res_entry(logic [9:0] slot, entry_type e);
      res_type r;
      r = '0;
      r.kind = KIND_ANSWER;
      r.status = STATUS_OK;
      r.result_slot = slot;
      r.result_handle = e.handle;
      r.result_backend_is_v6 = e.backend_pf[16];
      r.result_backend_hi = e.backend_hi;
      r.result_backend_lo = e.backend_lo;
      r.result_backend_port = e.backend_pf[15:0];
      r.result_last_seen = e.last_seen;
      r.last = 1'b1;
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/fto_free_stack.sv]
`default_nettype none
module fto_free_stack (
   input  wire                  clock,
   input  wire                  reset,
   input  fto_pkg::stk_cmd_type cmd,
   output fto_pkg::stk_stat_type stat
);

   logic [fto_pkg::SLOTW-1:0] stk_mem [fto_pkg::CAP];
   logic [fto_pkg::SLOTW-1:0] pop_ff;
   logic [fto_pkg::CNTW-1:0]  count_ff, count_in;
   logic [fto_pkg::SLOTW-1:0] init_cnt_ff;
   logic                      busy_ff;

   always_comb begin
      count_in = count_ff;
      if (cmd.push && count_ff < fto_pkg::CNTW'(fto_pkg::CAP)) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop && count_ff != '0) begin
         count_in = count_ff - 1'b1;
      end
   end

   // fill with descending slot numbers so that slot 0 sits on top
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         stk_mem[init_cnt_ff] <= fto_pkg::SLOTW'(fto_pkg::CAP - 1) - init_cnt_ff;
      end else if (cmd.push && count_ff < fto_pkg::CNTW'(fto_pkg::CAP)) begin
         stk_mem[count_ff[fto_pkg::SLOTW-1:0]] <= cmd.push_slot;
      end
      if (cmd.pop) begin
         pop_ff <= stk_mem[fto_pkg::SLOTW'(count_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         init_cnt_ff <= '0;
         count_ff    <= fto_pkg::CNTW'(fto_pkg::CAP);
      end else if (busy_ff) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
         if (init_cnt_ff == fto_pkg::SLOTW'(fto_pkg::CAP - 1)) begin
            busy_ff <= 1'b0;
         end
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.busy     = busy_ff;
   assign stat.count    = count_ff;
   assign stat.pop_slot = pop_ff;

endmodule
`default_nettype wire

[hdl/fto_engine.sv]
`default_nettype none
module fto_engine #(
   parameter int EVICT_SCAN_LIMIT = 4096
) (
   input  wire                 clock,
   input  wire                 reset,
   input  fto_pkg::cfg_type    cfg,
   input  wire                 req_valid,
   input  fto_pkg::req_type    req,
   output logic                req_ready,
   output logic                res_valid,
   output fto_pkg::res_type    res,
   input  wire                 res_ready
);

   localparam int SCANS = (fto_pkg::CAP < EVICT_SCAN_LIMIT) ? fto_pkg::CAP : EVICT_SCAN_LIMIT;
   localparam int EVCW  = $clog2(SCANS + 1);
   localparam int SW    = fto_pkg::SLOTW;
   localparam int IW    = fto_pkg::IDXW;

   typedef enum logic [28:0] {
      ST_INIT     = (29'd1 << 0),
      ST_IDLE     = (29'd1 << 1),
      ST_SEND     = (29'd1 << 2),
      ST_F_IDX    = (29'd1 << 3),
      ST_F_CHKIDX = (29'd1 << 4),
      ST_F_CHKENT = (29'd1 << 5),
      ST_R_RD     = (29'd1 << 6),
      ST_R_GOT    = (29'd1 << 7),
      ST_R_FOUND  = (29'd1 << 8),
      ST_D_RD     = (29'd1 << 9),
      ST_D_CHK    = (29'd1 << 10),
      ST_D_KEY    = (29'd1 << 11),
      ST_D_PUT    = (29'd1 << 12),
      ST_R_NOTE   = (29'd1 << 13),
      ST_R_FIN    = (29'd1 << 14),
      ST_EV_START = (29'd1 << 15),
      ST_EV_SCAN  = (29'd1 << 16),
      ST_EV_END   = (29'd1 << 17),
      ST_LK_DONE  = (29'd1 << 18),
      ST_P_F1     = (29'd1 << 19),
      ST_P_UPD    = (29'd1 << 20),
      ST_P_EV     = (29'd1 << 21),
      ST_P_POP    = (29'd1 << 22),
      ST_P_INS    = (29'd1 << 23),
      ST_S_CHK    = (29'd1 << 24),
      ST_S2_ANS   = (29'd1 << 25),
      ST_EVA_DONE = (29'd1 << 26),
      ST_X_RD     = (29'd1 << 27),
      ST_X_CHK    = (29'd1 << 28)
   } state_type;

   state_type state_ff, state_in, fret_ff, fret_in, rem_ret_ff, rem_ret_in;
   state_type ev_ret_ff, ev_ret_in, send_ret_ff, send_ret_in;

   fto_pkg::req_type   req_ff, req_in;
   fto_pkg::key_type   fkey_ff, fkey_in;
   logic [IW-1:0]      fpos_ff, fpos_in;
   logic               fmatch_ff, fmatch_in;
   logic [SW-1:0]      fslot_ff, fslot_in;
   fto_pkg::entry_type ent_hold_ff, ent_hold_in;
   logic [SW-1:0]      rem_slot_ff, rem_slot_in;
   fto_pkg::entry_type rem_word_ff, rem_word_in;
   logic [IW-1:0]      dcur_ff, dcur_in;
   logic [IW-1:0]      dstored_ff, dstored_in;
   logic               ev_ok_ff, ev_ok_in;
   logic [EVCW-1:0]    ev_cnt_ff, ev_cnt_in;
   logic               ev_pend_ff, ev_pend_in;
   logic               ev_found_ff, ev_found_in;
   logic [SW-1:0]      ev_victim_ff, ev_victim_in;
   logic [31:0]        ev_oldest_ff, ev_oldest_in;
   logic [SW-1:0]      ev_addr_ff, ev_addr_in;
   logic [SW-1:0]      evict_pos_ff, evict_pos_in;
   logic [SW-1:0]      expire_pos_ff, expire_pos_in;
   logic [5:0]         x_scanned_ff, x_scanned_in;
   logic [5:0]         x_expired_ff, x_expired_in;
   fto_pkg::res_type   res_ff, res_in;
   logic [IW-1:0]      clr_cnt_ff, clr_cnt_in;

   fto_pkg::entry_type ent_mem [fto_pkg::CAP];
   fto_pkg::entry_type ent_rdata_ff;
   logic [SW-1:0]      ent_ra, ent_wa;
   logic               ent_we;
   fto_pkg::entry_type ent_wd;

   logic [IW-1:0]      idx_mem [fto_pkg::IDX_CAP];
   logic [IW-1:0]      idx_rdata_ff;
   logic [IW-1:0]      idx_ra, idx_wa, idx_wd;
   logic               idx_we;

   fto_pkg::stk_cmd_type  stk_cmd;
   fto_pkg::stk_stat_type stk_stat;

   fto_free_stack u_free_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wa] <= ent_wd;
      end
      ent_rdata_ff <= ent_mem[ent_ra];
   end

   always_ff @(posedge clock) begin
      if (idx_we) begin
         idx_mem[idx_wa] <= idx_wd;
      end
      idx_rdata_ff <= idx_mem[idx_ra];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_SEND);
   assign res       = res_ff;

   always_comb begin
      fto_pkg::key_type   k;
      fto_pkg::entry_type e;
      logic               f;
      logic [SW-1:0]      v;
      logic [31:0]        o;
      logic [SW-1:0]      sa;
      logic [31:0]        age;

      state_in      = state_ff;
      fret_in       = fret_ff;
      rem_ret_in    = rem_ret_ff;
      ev_ret_in     = ev_ret_ff;
      send_ret_in   = send_ret_ff;
      req_in        = req_ff;
      fkey_in       = fkey_ff;
      fpos_in       = fpos_ff;
      fmatch_in     = fmatch_ff;
      fslot_in      = fslot_ff;
      ent_hold_in   = ent_hold_ff;
      rem_slot_in   = rem_slot_ff;
      rem_word_in   = rem_word_ff;
      dcur_in       = dcur_ff;
      dstored_in    = dstored_ff;
      ev_ok_in      = ev_ok_ff;
      ev_cnt_in     = ev_cnt_ff;
      ev_pend_in    = ev_pend_ff;
      ev_found_in   = ev_found_ff;
      ev_victim_in  = ev_victim_ff;
      ev_oldest_in  = ev_oldest_ff;
      ev_addr_in    = ev_addr_ff;
      evict_pos_in  = evict_pos_ff;
      expire_pos_in = expire_pos_ff;
      x_scanned_in  = x_scanned_ff;
      x_expired_in  = x_expired_ff;
      res_in        = res_ff;
      clr_cnt_in    = clr_cnt_ff;
      ent_ra = '0;
      ent_we = 1'b0;
      ent_wa = '0;
      ent_wd = '0;
      idx_ra = '0;
      idx_we = 1'b0;
      idx_wa = '0;
      idx_wd = '0;
      stk_cmd = '0;
      k  = fto_pkg::req_key(req);
      e  = ent_rdata_ff;
      f  = ev_found_ff;
      v  = ev_victim_ff;
      o  = ev_oldest_ff;
      sa = evict_pos_ff + SW'(ev_cnt_ff);
      age = req_ff.now - ent_rdata_ff.last_seen;

      unique case (state_ff)
         ST_INIT: begin
            idx_we = 1'b1;
            idx_wa = clr_cnt_ff;
            if (!clr_cnt_ff[IW-1]) begin
               ent_we = 1'b1;
               ent_wa = clr_cnt_ff[SW-1:0];
            end
            if (clr_cnt_ff != IW'(fto_pkg::IDX_CAP - 1)) begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end else if (!stk_stat.busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req;
               unique case (req.action)
                  fto_pkg::ACT_LOOKUP, fto_pkg::ACT_PUT: begin
                     fkey_in  = k;
                     fpos_in  = fto_pkg::key_hash(k);
                     fret_in  = (req.action == fto_pkg::ACT_PUT) ? ST_P_F1 : ST_LK_DONE;
                     state_in = ST_F_IDX;
                  end
                  fto_pkg::ACT_REMOVE, fto_pkg::ACT_READ: begin
                     ent_ra   = req.slot;
                     state_in = ST_S_CHK;
                  end
                  fto_pkg::ACT_EVICT: begin
                     ev_ret_in = ST_EVA_DONE;
                     state_in  = ST_EV_START;
                  end
                  fto_pkg::ACT_EXPIRE: begin
                     x_scanned_in = '0;
                     x_expired_in = '0;
                     state_in     = ST_X_RD;
                  end
                  default: begin
                     res_in      = fto_pkg::res_plain(fto_pkg::STATUS_MISS, '0, '0);
                     send_ret_in = ST_IDLE;
                     state_in    = ST_SEND;
                  end
               endcase
            end
         end
         ST_SEND: begin
            if (res_ready) begin
               state_in = send_ret_ff;
            end
         end
         ST_F_IDX: begin
            idx_ra   = fpos_ff;
            state_in = ST_F_CHKIDX;
         end
         ST_F_CHKIDX: begin
            if (idx_rdata_ff == '0) begin
               fmatch_in = 1'b0;
               state_in  = fret_ff;
            end else begin
               fslot_in = SW'(idx_rdata_ff - 1'b1);
               ent_ra   = SW'(idx_rdata_ff - 1'b1);
               state_in = ST_F_CHKENT;
            end
         end
         ST_F_CHKENT: begin
            if (e.used && e.key == fkey_ff) begin
               fmatch_in   = 1'b1;
               ent_hold_in = e;
               state_in    = fret_ff;
            end else begin
               fpos_in  = fpos_ff + 1'b1;
               state_in = ST_F_IDX;
            end
         end
         ST_R_RD: begin
            ent_ra   = rem_slot_ff;
            state_in = ST_R_GOT;
         end
         ST_R_GOT: begin
            rem_word_in = e;
            fkey_in     = e.key;
            fpos_in     = fto_pkg::key_hash(e.key);
            fret_in     = ST_R_FOUND;
            state_in    = ST_F_IDX;
         end
         ST_R_FOUND: begin
            if (fmatch_ff) begin
               idx_we   = 1'b1;
               idx_wa   = fpos_ff;
               dcur_in  = fpos_ff + 1'b1;
               state_in = ST_D_RD;
            end else begin
               state_in = ST_R_NOTE;
            end
         end
         ST_D_RD: begin
            idx_ra   = dcur_ff;
            state_in = ST_D_CHK;
         end
         ST_D_CHK: begin
            if (idx_rdata_ff == '0) begin
               state_in = ST_R_NOTE;
            end else begin
               // lift the entry out of the cluster, then find it a new home
               idx_we     = 1'b1;
               idx_wa     = dcur_ff;
               dstored_in = idx_rdata_ff;
               ent_ra     = SW'(idx_rdata_ff - 1'b1);
               state_in   = ST_D_KEY;
            end
         end
         ST_D_KEY: begin
            fkey_in  = e.key;
            fpos_in  = fto_pkg::key_hash(e.key);
            fret_in  = ST_D_PUT;
            state_in = ST_F_IDX;
         end
         ST_D_PUT: begin
            idx_we   = 1'b1;
            idx_wa   = fpos_ff;
            idx_wd   = dstored_ff;
            dcur_in  = dcur_ff + 1'b1;
            state_in = ST_D_RD;
         end
         ST_R_NOTE: begin
            res_in      = fto_pkg::res_notice(rem_slot_ff, rem_word_ff.handle);
            send_ret_in = ST_R_FIN;
            state_in    = ST_SEND;
         end
         ST_R_FIN: begin
            ent_we      = 1'b1;
            ent_wa      = rem_slot_ff;
            ent_wd      = rem_word_ff;
            ent_wd.used = 1'b0;
            stk_cmd.push      = (stk_stat.count < fto_pkg::CNTW'(fto_pkg::CAP));
            stk_cmd.push_slot = rem_slot_ff;
            state_in    = rem_ret_ff;
         end
         ST_EV_START: begin
            if (stk_stat.count == fto_pkg::CNTW'(fto_pkg::CAP)) begin
               ev_ok_in = 1'b0;
               state_in = ev_ret_ff;
            end else begin
               ev_cnt_in   = '0;
               ev_pend_in  = 1'b0;
               ev_found_in = 1'b0;
               state_in    = ST_EV_SCAN;
            end
         end
         ST_EV_SCAN: begin
            if (ev_pend_ff && e.used && (!f || e.last_seen < o)) begin
               f = 1'b1;
               v = ev_addr_ff;
               o = e.last_seen;
            end
            ev_found_in  = f;
            ev_victim_in = v;
            ev_oldest_in = o;
            if (ev_cnt_ff != EVCW'(SCANS)) begin
               ent_ra     = sa;
               ev_addr_in = sa;
               ev_pend_in = 1'b1;
               ev_cnt_in  = ev_cnt_ff + 1'b1;
            end else begin
               ev_pend_in = 1'b0;
               if (ev_pend_ff) begin
                  state_in = ST_EV_END;
               end
            end
         end
         ST_EV_END: begin
            evict_pos_in = evict_pos_ff + SW'(SCANS);
            if (ev_found_ff) begin
               ev_ok_in    = 1'b1;
               rem_slot_in = ev_victim_ff;
               rem_ret_in  = ev_ret_ff;
               state_in    = ST_R_RD;
            end else begin
               ev_ok_in = 1'b0;
               state_in = ev_ret_ff;
            end
         end
         ST_LK_DONE: begin
            if (fmatch_ff) begin
               res_in = fto_pkg::res_entry(fslot_ff, ent_hold_ff);
            end else begin
               res_in = fto_pkg::res_plain(fto_pkg::STATUS_MISS, '0, '0);
            end
            send_ret_in = ST_IDLE;
            state_in    = ST_SEND;
         end
         ST_P_F1: begin
            if (fmatch_ff) begin
               if (ent_hold_ff.handle != req_ff.handle) begin
                  res_in      = fto_pkg::res_notice(fslot_ff, ent_hold_ff.handle);
                  send_ret_in = ST_P_UPD;
                  state_in    = ST_SEND;
               end else begin
                  state_in = ST_P_UPD;
               end
            end else if (stk_stat.count == '0) begin
               ev_ret_in = ST_P_EV;
               state_in  = ST_EV_START;
            end else begin
               state_in = ST_P_POP;
            end
         end
         ST_P_UPD: begin
            e            = ent_hold_ff;
            e.used       = 1'b1;
            e.handle     = req_ff.handle;
            e.backend_pf = {req_ff.backend_is_v6, req_ff.backend_port};
            e.backend_hi = req_ff.backend_addr_hi;
            e.backend_lo = req_ff.backend_addr_lo;
            e.last_seen  = req_ff.now;
            ent_we       = 1'b1;
            ent_wa       = fslot_ff;
            ent_wd       = e;
            res_in       = fto_pkg::res_entry(fslot_ff, e);
            send_ret_in  = ST_IDLE;
            state_in     = ST_SEND;
         end
         ST_P_EV: begin
            if (!ev_ok_ff) begin
               res_in      = fto_pkg::res_plain(fto_pkg::STATUS_FULL, '0, '0);
               send_ret_in = ST_IDLE;
               state_in    = ST_SEND;
            end else begin
               fkey_in  = fto_pkg::req_key(req_ff);
               fpos_in  = fto_pkg::key_hash(fto_pkg::req_key(req_ff));
               fret_in  = ST_P_POP;
               state_in = ST_F_IDX;
            end
         end
         ST_P_POP: begin
            stk_cmd.pop = 1'b1;
            state_in    = ST_P_INS;
         end
         ST_P_INS: begin
            e.used       = 1'b1;
            e.handle     = req_ff.handle;
            e.key        = fto_pkg::req_key(req_ff);
            e.backend_pf = {req_ff.backend_is_v6, req_ff.backend_port};
            e.backend_hi = req_ff.backend_addr_hi;
            e.backend_lo = req_ff.backend_addr_lo;
            e.last_seen  = req_ff.now;
            ent_we       = 1'b1;
            ent_wa       = stk_stat.pop_slot;
            ent_wd       = e;
            idx_we       = 1'b1;
            idx_wa       = fpos_ff;
            idx_wd       = IW'(stk_stat.pop_slot) + 1'b1;
            res_in       = fto_pkg::res_entry(stk_stat.pop_slot, e);
            send_ret_in  = ST_IDLE;
            state_in     = ST_SEND;
         end
         ST_S_CHK: begin
            if (!e.used) begin
               res_in      = fto_pkg::res_plain(fto_pkg::STATUS_MISS, req_ff.slot, '0);
               send_ret_in = ST_IDLE;
               state_in    = ST_SEND;
            end else if (req_ff.action == fto_pkg::ACT_REMOVE) begin
               rem_slot_in = req_ff.slot;
               rem_ret_in  = ST_S2_ANS;
               state_in    = ST_R_RD;
            end else begin
               res_in      = fto_pkg::res_entry(req_ff.slot, e);
               send_ret_in = ST_IDLE;
               state_in    = ST_SEND;
            end
         end
         ST_S2_ANS: begin
            res_in      = fto_pkg::res_entry(req_ff.slot, rem_word_ff);
            send_ret_in = ST_IDLE;
            state_in    = ST_SEND;
         end
         ST_EVA_DONE: begin
            if (ev_ok_ff) begin
               res_in = fto_pkg::res_plain(fto_pkg::STATUS_OK, '0, 6'd1);
            end else begin
               res_in = fto_pkg::res_plain(fto_pkg::STATUS_MISS, '0, '0);
            end
            send_ret_in = ST_IDLE;
            state_in    = ST_SEND;
         end
         ST_X_RD: begin
            if (x_scanned_ff == cfg.expire_budget) begin
               res_in      = fto_pkg::res_plain(fto_pkg::STATUS_OK, '0, x_expired_ff);
               send_ret_in = ST_IDLE;
               state_in    = ST_SEND;
            end else begin
               ent_ra   = expire_pos_ff;
               state_in = ST_X_CHK;
            end
         end
         ST_X_CHK: begin
            expire_pos_in = expire_pos_ff + 1'b1;
            x_scanned_in  = x_scanned_ff + 1'b1;
            if (e.used && req_ff.now >= e.last_seen && age >= cfg.idle_timeout) begin
               x_expired_in = x_expired_ff + 1'b1;
               rem_slot_in  = expire_pos_ff;
               rem_ret_in   = ST_X_RD;
               state_in     = ST_R_RD;
            end else begin
               state_in = ST_X_RD;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         clr_cnt_ff    <= '0;
         evict_pos_ff  <= '0;
         expire_pos_ff <= '0;
         ev_pend_ff    <= 1'b0;
         fret_ff       <= ST_IDLE;
         rem_ret_ff    <= ST_IDLE;
         ev_ret_ff     <= ST_IDLE;
         send_ret_ff   <= ST_IDLE;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         evict_pos_ff  <= evict_pos_in;
         expire_pos_ff <= expire_pos_in;
         ev_pend_ff    <= ev_pend_in;
         fret_ff       <= fret_in;
         rem_ret_ff    <= rem_ret_in;
         ev_ret_ff     <= ev_ret_in;
         send_ret_ff   <= send_ret_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      fkey_ff      <= fkey_in;
      fpos_ff      <= fpos_in;
      fmatch_ff    <= fmatch_in;
      fslot_ff     <= fslot_in;
      ent_hold_ff  <= ent_hold_in;
      rem_slot_ff  <= rem_slot_in;
      rem_word_ff  <= rem_word_in;
      dcur_ff      <= dcur_in;
      dstored_ff   <= dstored_in;
      ev_ok_ff     <= ev_ok_in;
      ev_cnt_ff    <= ev_cnt_in;
      ev_found_ff  <= ev_found_in;
      ev_victim_ff <= ev_victim_in;
      ev_oldest_ff <= ev_oldest_in;
      ev_addr_ff   <= ev_addr_in;
      x_scanned_ff <= x_scanned_in;
      x_expired_ff <= x_expired_in;
      res_ff       <= res_in;
   end

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready && res.last) |=> state_ff == ST_IDLE)
      else $error("engine not idle after final beat");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      stk_cmd.pop |-> stk_stat.count != '0)
      else $error("pop from empty free stack");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      stk_cmd.push |-> stk_stat.count < fto_pkg::CNTW'(fto_pkg::CAP))
      else $error("push onto full free stack");

   a_scan_pending: assert property (@(posedge clock) disable iff (reset)
      ev_pend_ff |-> state_ff == ST_EV_SCAN)
      else $error("eviction read pending outside scan");

endmodule
`default_nettype wire

[hdl/flow_table_open_addressing_core.sv]
// Flow table keyed by client address family, 128-bit address and port, held in
// 1024 slots with an open-addressed index of 2048 positions probed linearly. After
// reset a clearing pass over all 2048 index positions runs and no request beat is
// taken until it ends; configuration writes are taken at any time. Each index probe
// has three steps (index read, entry read, compare). Removal adds a probe search
// for the removed key and one search per entry of the cluster that follows it.
// Evict scans min(1024, EVICT_SCAN_LIMIT) slots at one per cycle through the entry
// memory port. Expiry examines each slot in a read step and a check step, plus a
// removal for each expired entry. Every released handle comes out as a notice beat
// ahead of the one final answer beat; the engine stalls while the result register
// is full.
`default_nettype none
module flow_table_open_addressing_core #(
   parameter int EVICT_SCAN_LIMIT = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [7:0]  csr_index,
   input  wire  [31:0] csr_wdata,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [2:0]  req_action,
   input  wire         req_client_is_v6,
   input  wire  [63:0] req_client_addr_hi,
   input  wire  [63:0] req_client_addr_lo,
   input  wire  [15:0] req_client_port,
   input  wire         req_backend_is_v6,
   input  wire  [63:0] req_backend_addr_hi,
   input  wire  [63:0] req_backend_addr_lo,
   input  wire  [15:0] req_backend_port,
   input  wire  [15:0] req_handle,
   input  wire  [31:0] req_now,
   input  wire  [9:0]  req_slot,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_result_slot,
   output logic [15:0] rsp_result_handle,
   output logic        rsp_result_backend_is_v6,
   output logic [63:0] rsp_result_backend_hi,
   output logic [63:0] rsp_result_backend_lo,
   output logic [15:0] rsp_result_backend_port,
   output logic [31:0] rsp_result_last_seen,
   output logic [5:0]  rsp_removed_count,
   output logic        rsp_last
);

   fto_pkg::cfg_type cfg_ff;
   fto_pkg::req_type req_bus;
   fto_pkg::res_type res_bus, rsp_ff;
   logic             res_valid, res_ready, rsp_valid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout  <= 32'd30;
         cfg_ff.expire_budget <= 6'd16;
      end else if (csr_valid) begin
         if (csr_index == fto_pkg::CSR_IDLE_TIMEOUT) begin
            cfg_ff.idle_timeout <= csr_wdata;
         end else if (csr_index == fto_pkg::CSR_EXPIRE_BUDGET) begin
            cfg_ff.expire_budget <= csr_wdata[5:0];
         end
      end
   end

   assign req_bus.action          = req_action;
   assign req_bus.client_is_v6    = req_client_is_v6;
   assign req_bus.client_addr_hi  = req_client_addr_hi;
   assign req_bus.client_addr_lo  = req_client_addr_lo;
   assign req_bus.client_port     = req_client_port;
   assign req_bus.backend_is_v6   = req_backend_is_v6;
   assign req_bus.backend_addr_hi = req_backend_addr_hi;
   assign req_bus.backend_addr_lo = req_backend_addr_lo;
   assign req_bus.backend_port    = req_backend_port;
   assign req_bus.handle          = req_handle;
   assign req_bus.now             = req_now;
   assign req_bus.slot            = req_slot;

   fto_engine #(
      .EVICT_SCAN_LIMIT (EVICT_SCAN_LIMIT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req       (req_bus),
      .req_ready (req_ready),
      .res_valid (res_valid),
      .res       (res_bus),
      .res_ready (res_ready)
   );

   // hold a beat until taken; refill in the same cycle it leaves
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res_bus;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_kind                 = rsp_ff.kind;
   assign rsp_status               = rsp_ff.status;
   assign rsp_result_slot          = rsp_ff.result_slot;
   assign rsp_result_handle        = rsp_ff.result_handle;
   assign rsp_result_backend_is_v6 = rsp_ff.result_backend_is_v6;
   assign rsp_result_backend_hi    = rsp_ff.result_backend_hi;
   assign rsp_result_backend_lo    = rsp_ff.result_backend_lo;
   assign rsp_result_backend_port  = rsp_ff.result_backend_port;
   assign rsp_result_last_seen     = rsp_ff.result_last_seen;
   assign rsp_removed_count        = rsp_ff.removed_count;
   assign rsp_last                 = rsp_ff.last;

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import fto_pkg::*;

   localparam int    LIMIT_CYCLES = 20_000_000;
   localparam int    LONG_HOLD    = 3000;
   localparam int    KEY_POOL     = 48;

   typedef logic [144:0] flow_key_bits;

   class flow_scoreboard;
      bit           used [CAP];
      logic [15:0]  hnd [CAP];
      flow_key_bits key [CAP];
      logic [16:0]  bpf [CAP];
      logic [63:0]  bhi [CAP];
      logic [63:0]  blo [CAP];
      logic [31:0]  seen [CAP];
      int           slot_of [flow_key_bits];
      int           free_stack [CAP];
      int           free_cnt, live_cnt, evict_pos, expire_pos;
      logic [31:0]  timeout;
      int           budget;
      res_type      awaited [$];
      int           mismatches;

      function new();
         for (int i = 0; i < CAP; i++) begin
            used[i] = 0;
            free_stack[i] = CAP - 1 - i;
         end
         free_cnt = CAP;
         live_cnt = 0;
         evict_pos = 0;
         expire_pos = 0;
         timeout = 32'd30;
         budget = 16;
         mismatches = 0;
      endfunction

      function void set_reg(logic [7:0] idx, logic [31:0] val);
         if (idx == CSR_IDLE_TIMEOUT) timeout = val;
         else if (idx == CSR_EXPIRE_BUDGET) budget = val[5:0];
      endfunction

      function void push_plain(logic [1:0] st, logic [9:0] s, logic [5:0] removed);
         res_type r;
         r = '0;
         r.kind = KIND_ANSWER;
         r.status = st;
         r.result_slot = s;
         r.removed_count = removed;
         r.last = 1'b1;
         awaited.push_back(r);
      endfunction

      function void push_entry(int s);
         res_type r;
         r = '0;
         r.kind = KIND_ANSWER;
         r.status = STATUS_OK;
         r.result_slot = s[9:0];
         r.result_handle = hnd[s];
         r.result_backend_is_v6 = bpf[s][16];
         r.result_backend_hi = bhi[s];
         r.result_backend_lo = blo[s];
         r.result_backend_port = bpf[s][15:0];
         r.result_last_seen = seen[s];
         r.last = 1'b1;
         awaited.push_back(r);
      endfunction

      function void push_notice(int s, logic [15:0] h);
         res_type r;
         r = '0;
         r.kind = KIND_NOTICE;
         r.status = STATUS_OK;
         r.result_slot = s[9:0];
         r.result_handle = h;
         awaited.push_back(r);
      endfunction

      function void release_slot(int s);
         slot_of.delete(key[s]);
         push_notice(s, hnd[s]);
         used[s] = 0;
         free_stack[free_cnt++] = s;
         live_cnt--;
      endfunction

      // full scan from the evict position; the position comes back to itself
      function bit evict_oldest();
         int victim;
         bit found;
         int s;
         found = 0;
         victim = 0;
         if (live_cnt == 0) return 0;
         for (int i = 0; i < CAP; i++) begin
            s = (evict_pos + i) % CAP;
            if (used[s] && (!found || seen[s] < seen[victim])) begin
               found = 1;
               victim = s;
            end
         end
         if (!found) return 0;
         release_slot(victim);
         return 1;
      endfunction

      function void note(req_type r);
         flow_key_bits k;
         int s;
         int scanned, expired;
         k = {r.client_is_v6, r.client_port, r.client_addr_hi, r.client_addr_lo};
         case (r.action)
            ACT_LOOKUP: begin
               if (slot_of.exists(k)) push_entry(slot_of[k]);
               else push_plain(STATUS_MISS, 10'd0, 6'd0);
            end
            ACT_PUT: begin
               if (slot_of.exists(k)) begin
                  s = slot_of[k];
                  if (hnd[s] != r.handle) push_notice(s, hnd[s]);
               end else begin
                  if (free_cnt == 0 && !evict_oldest()) begin
                     push_plain(STATUS_FULL, 10'd0, 6'd0);
                     return;
                  end
                  s = free_stack[--free_cnt];
                  used[s] = 1;
                  key[s] = k;
                  slot_of[k] = s;
                  live_cnt++;
               end
               hnd[s] = r.handle;
               bpf[s] = {r.backend_is_v6, r.backend_port};
               bhi[s] = r.backend_addr_hi;
               blo[s] = r.backend_addr_lo;
               seen[s] = r.now;
               push_entry(s);
            end
            ACT_REMOVE: begin
               if (used[r.slot]) begin
                  s = r.slot;
                  release_slot(s);
                  push_entry(s);
               end else push_plain(STATUS_MISS, r.slot, 6'd0);
            end
            ACT_EVICT: begin
               if (evict_oldest()) push_plain(STATUS_OK, 10'd0, 6'd1);
               else push_plain(STATUS_MISS, 10'd0, 6'd0);
            end
            ACT_EXPIRE: begin
               expired = 0;
               for (scanned = 0; scanned < budget && scanned < CAP; scanned++) begin
                  s = expire_pos;
                  if (used[s] && r.now >= seen[s] && r.now - seen[s] >= timeout) begin
                     release_slot(s);
                     expired++;
                  end
                  expire_pos = (s + 1) % CAP;
               end
               push_plain(STATUS_OK, 10'd0, expired[5:0]);
            end
            ACT_READ: begin
               if (used[r.slot]) push_entry(r.slot);
               else push_plain(STATUS_MISS, r.slot, 6'd0);
            end
            default: push_plain(STATUS_MISS, 10'd0, 6'd0);
         endcase
      endfunction

      function void check(res_type got);
         res_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", got);
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch at %0t", $realtime);
               $display("  expected %p", want);
               $display("  actual   %p", got);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   res_type     rsp;

   flow_scoreboard flows = new();
   int           burst_left = 0;
   int           hold_left = 0;
   bit           hold_request = 0;
   int           cycles = 0;
   logic [31:0]  clock_secs = 32'd100;
   req_type      pool [KEY_POOL];

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   flow_table_open_addressing_core dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req.action), .req_client_is_v6(req.client_is_v6),
      .req_client_addr_hi(req.client_addr_hi), .req_client_addr_lo(req.client_addr_lo),
      .req_client_port(req.client_port), .req_backend_is_v6(req.backend_is_v6),
      .req_backend_addr_hi(req.backend_addr_hi), .req_backend_addr_lo(req.backend_addr_lo),
      .req_backend_port(req.backend_port), .req_handle(req.handle),
      .req_now(req.now), .req_slot(req.slot),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kind(rsp.kind), .rsp_status(rsp.status),
      .rsp_result_slot(rsp.result_slot), .rsp_result_handle(rsp.result_handle),
      .rsp_result_backend_is_v6(rsp.result_backend_is_v6),
      .rsp_result_backend_hi(rsp.result_backend_hi),
      .rsp_result_backend_lo(rsp.result_backend_lo),
      .rsp_result_backend_port(rsp.result_backend_port),
      .rsp_result_last_seen(rsp.result_last_seen),
      .rsp_removed_count(rsp.removed_count), .rsp_last(rsp.last)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) flows.check(rsp);
      if (cycles >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: alternate between free-running and random stalls; long hold on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 0;
      end else if ((cycles / 300) % 3 == 0) rsp_ready = 1;
      else rsp_ready = ($urandom_range(0, 99) < 65);
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type rand_key_req();
      req_type r;
      r = '0;
      r.client_is_v6 = $urandom_range(0, 1);
      r.client_addr_hi = rand64();
      r.client_addr_lo = rand64();
      r.client_port = $urandom;
      return r;
   endfunction

   function automatic req_type flow_req(logic [2:0] act, req_type k);
      req_type r;
      r = k;
      r.action = act;
      r.backend_is_v6 = $urandom_range(0, 1);
      r.backend_addr_hi = rand64();
      r.backend_addr_lo = rand64();
      r.backend_port = $urandom;
      r.handle = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      r.now = clock_secs;
      r.slot = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
      return r;
   endfunction

   task automatic send(input req_type r);
      if (burst_left == 0) begin
         req_valid = 0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req = r;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      flows.note(r);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 0;
      burst_left = 0;
      wait (flows.awaited.size() == 0);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      flows.set_reg(idx, val);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic random_items(input int count);
      req_type r;
      int pick;
      for (int i = 0; i < count; i++) begin
         clock_secs += $urandom_range(0, 3);
         r = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, KEY_POOL - 1)]
                                           : rand_key_req();
         pick = $urandom_range(0, 99);
         if (pick < 35)      r = flow_req(ACT_PUT, r);
         else if (pick < 55) r = flow_req(ACT_LOOKUP, r);
         else if (pick < 67) r = flow_req(ACT_READ, r);
         else if (pick < 77) r = flow_req(ACT_REMOVE, r);
         else if (pick < 82) r = flow_req(ACT_EVICT, r);
         else if (pick < 94) r = flow_req(ACT_EXPIRE, r);
         else                r = flow_req(3'($urandom_range(6, 7)), r);
         // stale or far-future time now and then
         if ($urandom_range(0, 29) == 0) r.now = $urandom;
         send(r);
      end
   endtask

   initial begin
      req_type r;
      for (int i = 0; i < KEY_POOL; i++) pool[i] = rand_key_req();
      pool[0].client_is_v6 = 1;
      pool[0].client_addr_hi = '1;
      pool[0].client_addr_lo = '1;
      pool[0].client_port = '1;
      pool[1] = '0;
      repeat (2) @(negedge clock);
      reset = 0;

      // directed
      send(flow_req(ACT_EVICT, pool[0]));
      send(flow_req(ACT_LOOKUP, pool[0]));
      r = flow_req(ACT_PUT, pool[0]);
      r.handle = 16'hFFFF;
      r.backend_is_v6 = 1;
      r.backend_addr_hi = '1;
      r.backend_addr_lo = '1;
      r.backend_port = '1;
      r.now = 32'hFFFF_FFFF;
      send(r);
      send(r);
      r.handle = 16'h0000;
      send(r);
      r = flow_req(ACT_PUT, pool[1]);
      r.handle = 16'h0000;
      r.backend_is_v6 = 0;
      r.backend_addr_hi = '0;
      r.backend_addr_lo = '0;
      r.backend_port = '0;
      r.now = '0;
      send(r);
      send(flow_req(ACT_LOOKUP, pool[1]));
      send(flow_req(ACT_LOOKUP, pool[2]));
      r = flow_req(ACT_READ, pool[2]);
      r.slot = 10'd0;
      send(r);
      r.slot = 10'd1023;
      send(r);
      r.action = ACT_REMOVE;
      send(r);
      r.now = 32'd40;
      r.action = ACT_EXPIRE;
      send(r);
      r.action = 3'd6;
      send(r);
      r.action = 3'd7;
      send(r);
      send(flow_req(ACT_PUT, pool[2]));
      send(flow_req(ACT_EVICT, pool[2]));
      r = flow_req(ACT_REMOVE, pool[2]);
      r.slot = 10'd1;
      send(r);
      send(r);
      drain();

      // default settings, with one long receiver hold while items keep coming
      random_items(60);
      hold_request = 1;
      random_items(140);
      drain();

      write_reg(CSR_IDLE_TIMEOUT, 32'hFFFF_FFFF);
      write_reg(CSR_EXPIRE_BUDGET, 32'd1);
      random_items(100);
      drain();

      // fill the table past capacity so puts evict the oldest
      write_reg(CSR_IDLE_TIMEOUT, 32'd5);
      write_reg(CSR_EXPIRE_BUDGET, 32'd63);
      for (int i = 0; i < CAP + 24; i++) begin
         clock_secs += $urandom_range(0, 1);
         send(flow_req(ACT_PUT, rand_key_req()));
      end
      random_items(40);
      drain();

      // sweep everything out
      write_reg(CSR_IDLE_TIMEOUT, 32'd0);
      for (int i = 0; i < 20; i++) send(flow_req(ACT_EXPIRE, pool[0]));
      drain();

      write_reg(CSR_IDLE_TIMEOUT, 32'd4);
      write_reg(CSR_EXPIRE_BUDGET, 32'd40);
      random_items(100);
      drain();
      repeat (3000) @(negedge clock);

      if (flows.mismatches == 0 && flows.awaited.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
